// File: hw/rtl/crla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crla_pkg
// Shared constants and types for the CR/LF line assembler.
// ----------------------------------------------------------------------------
package crla_pkg;

  // Line store depth (payload bytes, 2..64)
  localparam int LINE_BYTES  = 64;
  localparam int CNT_W       = $clog2(LINE_BYTES);
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 6;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;

  // Byte class decided by the front
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_CR   = 2'd1,
    KIND_LF   = 2'd2
  } kind_t;

  // One classified request
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
  } req_t;

endpackage
`default_nettype wire

// File: hw/rtl/crla_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crla_front
// Input stage: accepts received bytes, classifies them, holds one request.
// ----------------------------------------------------------------------------
module crla_front
  import crla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rx_valid,
  output logic                   rx_ready,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output req_t                   push_req
);

  logic held;
  req_t req;
  req_t req_next;

  // Classify the incoming byte
  always_comb begin
    req_next.data = rx_byte;
    if (rx_byte == CHAR_LF) begin
      req_next.kind = KIND_LF;
    end else if (rx_byte == CHAR_CR) begin
      req_next.kind = KIND_CR;
    end else begin
      req_next.kind = KIND_DATA;
    end
  end

  assign rx_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_req   = req;

  // Hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (rx_ready) begin
      held <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      req <= req_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/crla_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crla_queue
// Short request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module crla_queue
  import crla_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire req_t push_req,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output req_t      pop_req
);

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_req    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/crla_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crla_back
// Line state, line store and output drain.
// ----------------------------------------------------------------------------
module crla_back
  import crla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire req_t              pop_req,
  output logic                   line_valid,
  input  wire logic              line_ready,
  output logic [BYTE_W-1:0]      line_byte,
  output logic [LEN_W-1:0]       line_length,
  output logic                   last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  state_t            state;
  logic              sink_enable;
  logic [CNT_W-1:0]  count;
  logic              seen_cr;
  logic              line_done;
  logic [CNT_W-1:0]  rd_idx;
  logic [BYTE_W-1:0] store [LINE_BYTES];
  logic [BYTE_W-1:0] rdata;
  logic              take;
  logic              store_wr;
  logic              out_free;
  logic              is_last;

  assign pop_ready = (state == ST_IDLE);
  assign take      = pop_valid && pop_ready;
  assign store_wr  = take && !line_done && !seen_cr && (pop_req.kind != KIND_CR);
  assign out_free  = !line_valid || line_ready;
  assign is_last   = (rd_idx == count - 1'b1);

  // Sink enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      sink_enable <= 1'b1;
    end else if (cfg_we) begin
      sink_enable <= cfg_wdata;
    end
  end

  // Line store: write at the fill position, registered read for the drain
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store[count] <= pop_req.data;
    end
    rdata <= store[rd_idx];
  end

  // Line state machine and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      seen_cr    <= 1'b0;
      line_done  <= 1'b0;
      rd_idx     <= '0;
      line_valid <= 1'b0;
    end else begin
      if (line_valid && line_ready && state != ST_SEND) begin
        line_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (line_done || (seen_cr && pop_req.kind == KIND_LF)) begin
              // Line complete (now or earlier): emit or drop when sink is on
              line_done <= 1'b1;
              if (sink_enable) begin
                if (count == '0) begin
                  seen_cr   <= 1'b0;
                  line_done <= 1'b0;
                end else begin
                  rd_idx <= '0;
                  state  <= ST_READ;
                end
              end
            end else if (seen_cr) begin
              // Anything but LF after CR discards the line
              count   <= '0;
              seen_cr <= 1'b0;
            end else if (pop_req.kind == KIND_CR) begin
              seen_cr <= 1'b1;
            end else if (count == CNT_W'(LINE_BYTES - 1)) begin
              // Store full: discard
              count <= '0;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        ST_READ: begin
          state <= ST_SEND;
        end
        ST_SEND: begin
          if (out_free) begin
            line_valid  <= 1'b1;
            line_byte   <= rdata;
            line_length <= LEN_W'(count);
            last        <= is_last;
            if (is_last) begin
              count     <= '0;
              seen_cr   <= 1'b0;
              line_done <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              rd_idx <= rd_idx + 1'b1;
              state  <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Draining only happens for a completed, non-empty line
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (line_done && count != '0))
    else $error("drain without a completed line");

  // Drain index stays inside the line
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND) |-> (rd_idx < count))
    else $error("drain index beyond line length");

  // Sending the last byte clears the line
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND && out_free && is_last) |=>
      (state == ST_IDLE && !line_done && count == '0 && last && line_valid))
    else $error("line not cleared after last byte");

  // Fill count never reaches the store depth
  assert property (@(posedge clk) disable iff (rst)
    take |=> (32'(count) < LINE_BYTES))
    else $error("fill count overflow");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/crlf_line_assembler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crlf_line_assembler_unit
// Assembles CR/LF terminated lines from received bytes and emits them.
// ----------------------------------------------------------------------------
// Bytes enter on rx_valid/rx_ready, one per cycle, into an input register and
// a two-entry request queue; the back end retires one byte request per cycle
// while idle. A byte that completes a non-empty line while sink_enable is set
// (or any byte while a held line waits and the sink is enabled) starts the
// drain: each stored byte passes through ST_READ (line store read), then
// ST_SEND (output register), so a line occupies the back end, and input
// stalls once the queue has filled. The line store needs no clearing after
// reset.
module crlf_line_assembler_unit
  import crla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              rx_valid,
  output logic                   rx_ready,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output logic                   line_valid,
  input  wire logic              line_ready,
  output logic [BYTE_W-1:0]      line_byte,
  output logic [LEN_W-1:0]       line_length,
  output logic                   last
);

  logic push_valid;
  logic push_ready;
  req_t push_req;
  logic pop_valid;
  logic pop_ready;
  req_t pop_req;

  crla_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  crla_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req)
  );

  crla_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_req     (pop_req),
    .line_valid  (line_valid),
    .line_ready  (line_ready),
    .line_byte   (line_byte),
    .line_length (line_length),
    .last        (last)
  );

endmodule
`default_nettype wire
